>>> rtl/svml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Surface voxel majority label package
// Shared constants and lane status type for the six-neighbor mode filter.
// ----------------------------------------------------------------------------
package svml_pkg;

  localparam int unsigned PortLabelW = 32;
  localparam int unsigned NumNeigh   = 6;
  localparam int unsigned CntW       = 3;
  localparam logic [PortLabelW-1:0] FgReset = 32'd2;

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [CntW-1:0] cnt;
  } lane_flags_t;

endpackage

>>> rtl/svml_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Surface voxel majority label channels
// Valid/ready request channel carrying a voxel and its six face neighbors,
// and result channel carrying the surface label and flags.
// ----------------------------------------------------------------------------
interface svml_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] centre_label;
  logic [31:0] x_minus_label;
  logic [31:0] x_plus_label;
  logic [31:0] y_minus_label;
  logic [31:0] y_plus_label;
  logic [31:0] z_minus_label;
  logic [31:0] z_plus_label;

  modport source (
    output valid, centre_label, x_minus_label, x_plus_label,
    output y_minus_label, y_plus_label, z_minus_label, z_plus_label,
    input  ready
  );
  modport sink (
    input  valid, centre_label, x_minus_label, x_plus_label,
    input  y_minus_label, y_plus_label, z_minus_label, z_plus_label,
    output ready
  );
endinterface

interface svml_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] surface_label;
  logic        surface_flag;
  logic        orphan_flag;

  modport source (
    output valid, surface_label, surface_flag, orphan_flag,
    input  ready
  );
  modport sink (
    input  valid, surface_label, surface_flag, orphan_flag,
    output ready
  );
endinterface

>>> rtl/svml_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Surface voxel majority label lane
// Counts how often one neighbor label occurs among all six neighbors and
// registers whether it is a non-foreground candidate of a foreground centre.
// ----------------------------------------------------------------------------
module svml_lane
  import svml_pkg::*;
#(
  parameter int unsigned LABEL_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic                                  centre_fg_i,
  input  logic [LABEL_WIDTH-1:0]                fg_i,
  input  logic [LABEL_WIDTH-1:0]                own_i,
  input  logic [NumNeigh-1:0][LABEL_WIDTH-1:0]  nb_i,
  output lane_flags_t                           flags_o,
  output logic [LABEL_WIDTH-1:0]                label_o
);

  lane_flags_t            flags_d, flags_q;
  logic [LABEL_WIDTH-1:0] label_q;

  always_comb begin
    flags_d.valid = centre_fg_i && (own_i != fg_i);
    flags_d.zero  = (own_i == '0);
    flags_d.cnt   = '0;
    for (int k = 0; k < NumNeigh; k++) begin
      if (nb_i[k] == own_i) begin
        flags_d.cnt = flags_d.cnt + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q <= flags_d;
      label_q <= own_i;
    end
  end

  assign flags_o = flags_q;
  assign label_o = label_q;

endmodule

>>> rtl/svml_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Surface voxel majority label merge
// Selects the most frequent candidate across the lanes, smallest label on a
// tie, through a three-level compare tree and registers the result.
// ----------------------------------------------------------------------------
module svml_merge
  import svml_pkg::*;
#(
  parameter int unsigned LABEL_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  lane_flags_t [NumNeigh-1:0]            flags_i,
  input  logic [NumNeigh-1:0][LABEL_WIDTH-1:0]  label_i,
  output logic [LABEL_WIDTH-1:0]                label_o,
  output logic                                  surface_o,
  output logic                                  orphan_o
);

  function automatic logic b_wins(
    input lane_flags_t            fa,
    input logic [LABEL_WIDTH-1:0] la,
    input lane_flags_t            fb,
    input logic [LABEL_WIDTH-1:0] lb
  );
    logic r;
    if (!fb.valid) begin
      r = 1'b0;
    end else if (!fa.valid) begin
      r = 1'b1;
    end else begin
      r = (fb.cnt > fa.cnt) || ((fb.cnt == fa.cnt) && (lb < la));
    end
    return r;
  endfunction

  lane_flags_t            f01, f23, f45, f03, fall;
  logic [LABEL_WIDTH-1:0] l01, l23, l45, l03, lall;
  logic [LABEL_WIDTH-1:0] label_d, label_q;
  logic                   surface_d, surface_q;
  logic                   orphan_d, orphan_q;

  always_comb begin
    if (b_wins(flags_i[0], label_i[0], flags_i[1], label_i[1])) begin
      f01 = flags_i[1];
      l01 = label_i[1];
    end else begin
      f01 = flags_i[0];
      l01 = label_i[0];
    end
    if (b_wins(flags_i[2], label_i[2], flags_i[3], label_i[3])) begin
      f23 = flags_i[3];
      l23 = label_i[3];
    end else begin
      f23 = flags_i[2];
      l23 = label_i[2];
    end
    if (b_wins(flags_i[4], label_i[4], flags_i[5], label_i[5])) begin
      f45 = flags_i[5];
      l45 = label_i[5];
    end else begin
      f45 = flags_i[4];
      l45 = label_i[4];
    end
    if (b_wins(f01, l01, f23, l23)) begin
      f03 = f23;
      l03 = l23;
    end else begin
      f03 = f01;
      l03 = l01;
    end
    if (b_wins(f03, l03, f45, l45)) begin
      fall = f45;
      lall = l45;
    end else begin
      fall = f03;
      lall = l03;
    end

    label_d   = fall.valid ? lall : '0;
    surface_d = 1'b0;
    orphan_d  = 1'b0;
    for (int i = 0; i < NumNeigh; i++) begin
      surface_d = surface_d | flags_i[i].valid;
      orphan_d  = orphan_d | (flags_i[i].valid & flags_i[i].zero);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      label_q   <= label_d;
      surface_q <= surface_d;
      orphan_q  <= orphan_d;
    end
  end

  assign label_o   = label_q;
  assign surface_o = surface_q;
  assign orphan_o  = orphan_q;

endmodule

>>> rtl/surface_voxel_majority_label.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Surface voxel majority label
// Six-neighbor mode filter for foreground surface voxels, built from six
// counting lanes and a merging compare tree.
// ----------------------------------------------------------------------------
// A request is registered first in the lane registers and then in the merge
// output register, which drives the result.
// Throughput is one request per cycle; each stage stalls only when the stage
// after it holds a result that has not been taken.
// Reset clears both stage valid bits and loads the foreground label with 2.
module surface_voxel_majority_label
  import svml_pkg::*;
#(
  parameter int unsigned LABEL_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fg_we_i,
  input  logic [PortLabelW-1:0] fg_wdata_i,
  svml_in_if.sink               req_i,
  svml_out_if.source            res_o
);

  logic [LABEL_WIDTH-1:0]                fg_q;
  logic [LABEL_WIDTH-1:0]                centre;
  logic [NumNeigh-1:0][LABEL_WIDTH-1:0]  nb;
  lane_flags_t [NumNeigh-1:0]            lane_flags;
  logic [NumNeigh-1:0][LABEL_WIDTH-1:0]  lane_label;
  logic [LABEL_WIDTH-1:0]                merge_label;
  logic                                  merge_surface;
  logic                                  merge_orphan;
  logic                                  s1_v_q, s1_v_d;
  logic                                  s2_v_q, s2_v_d;
  logic                                  s1_load, s2_load;
  logic                                  s1_ready, s2_ready;
  logic                                  centre_fg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FgReset[LABEL_WIDTH-1:0];
    end else if (fg_we_i) begin
      fg_q <= fg_wdata_i[LABEL_WIDTH-1:0];
    end
  end

  always_comb begin
    centre = req_i.centre_label[LABEL_WIDTH-1:0];
    nb[0]  = req_i.x_minus_label[LABEL_WIDTH-1:0];
    nb[1]  = req_i.x_plus_label[LABEL_WIDTH-1:0];
    nb[2]  = req_i.y_minus_label[LABEL_WIDTH-1:0];
    nb[3]  = req_i.y_plus_label[LABEL_WIDTH-1:0];
    nb[4]  = req_i.z_minus_label[LABEL_WIDTH-1:0];
    nb[5]  = req_i.z_plus_label[LABEL_WIDTH-1:0];
    centre_fg = (centre == fg_q);

    s2_ready = !s2_v_q || res_o.ready;
    s1_ready = !s1_v_q || s2_ready;
    s1_load  = req_i.valid && s1_ready;
    s2_load  = s1_v_q && s2_ready;
    s1_v_d   = s1_ready ? req_i.valid : s1_v_q;
    s2_v_d   = s2_ready ? s1_v_q : s2_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  for (genvar g = 0; g < NumNeigh; g++) begin : g_lane
    svml_lane #(
      .LABEL_WIDTH(LABEL_WIDTH)
    ) u_lane (
      .clk_i       (clk_i),
      .load_i      (s1_load),
      .centre_fg_i (centre_fg),
      .fg_i        (fg_q),
      .own_i       (nb[g]),
      .nb_i        (nb),
      .flags_o     (lane_flags[g]),
      .label_o     (lane_label[g])
    );
  end

  svml_merge #(
    .LABEL_WIDTH(LABEL_WIDTH)
  ) u_merge (
    .clk_i     (clk_i),
    .load_i    (s2_load),
    .flags_i   (lane_flags),
    .label_i   (lane_label),
    .label_o   (merge_label),
    .surface_o (merge_surface),
    .orphan_o  (merge_orphan)
  );

  assign req_i.ready         = s1_ready;
  assign res_o.valid         = s2_v_q;
  assign res_o.surface_label = PortLabelW'(merge_label);
  assign res_o.surface_flag  = merge_surface;
  assign res_o.orphan_flag   = merge_orphan;

endmodule
